// ===== design/deltest_pkg.sv =====
// ----------------------------------------------------------------------------
// deltest_pkg: shared type for the Delaunay edge legality test
// Holds the verdict codes carried on the result beat.
// ----------------------------------------------------------------------------
package deltest_pkg;

  typedef enum logic [2:0] {
    VERDICT_SAME       = 3'd0,
    VERDICT_NOT_CONVEX = 3'd1,
    VERDICT_ACUTE      = 3'd2,
    VERDICT_SUM_PASS   = 3'd3,
    VERDICT_FLIP       = 3'd4
  } verdict_t;

endpackage

// ===== design/delaunay_edge_legality_test.sv =====
// An accepted input beat passes stage registers 1 through 7 to its result beat on the output.
// Throughput: one quadrilateral per cycle while the output is not stalled; seven register stages.
// The widest step is the split mixed-sum product (four partial multipliers per
// product, stage 5).
// A stalled stage holds and upstream stages fill bubbles before stalling too.
// Reset clears the stage valid bits only; payload registers are not reset.
// ----------------------------------------------------------------------------
// delaunay_edge_legality_test
// Decides whether the shared edge of a quadrilateral is kept or flipped,
// using the convexity check and the exact angle-sum swap test.
// ----------------------------------------------------------------------------
module delaunay_edge_legality_test
  import deltest_pkg::*;
#(
  parameter int COORD_BITS = 16,
  parameter int TOLERANCE  = 0
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COORD_BITS-1:0] left_x,
  input  logic signed [COORD_BITS-1:0] left_y,
  input  logic signed [COORD_BITS-1:0] right_x,
  input  logic signed [COORD_BITS-1:0] right_y,
  input  logic signed [COORD_BITS-1:0] top_x,
  input  logic signed [COORD_BITS-1:0] top_y,
  input  logic signed [COORD_BITS-1:0] bottom_x,
  input  logic signed [COORD_BITS-1:0] bottom_y,
  input  logic                         same_vertex,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         keep_edge,
  output logic [2:0]                   verdict
);

  // Width plan: coordinate differences, their products, sums of two products,
  // the split of the magnitudes for the final products, and the mixed sum.
  localparam int DW   = COORD_BITS + 1;
  localparam int PW   = 2 * DW;
  localparam int SW   = PW + 1;
  localparam int MW   = SW;
  localparam int LO   = (MW + 1) / 2;
  localparam int HI   = MW - LO;
  localparam int FW   = 2 * MW;
  localparam int SUMW = FW + 2;

  localparam logic signed [SW:0]     TOL_S   = (SW + 1)'(TOLERANCE);
  localparam logic signed [SUMW-1:0] TOL_SUM = SUMW'(TOLERANCE);

  // Stage enables: a stage advances when empty or when the next one advances.
  logic en1, en2, en3, en4, en5, en6, en7;
  logic s1_valid, s2_valid, s3_valid, s4_valid, s5_valid, s6_valid, s7_valid;

  assign en7 = !s7_valid || !out_stall;
  assign en6 = !s6_valid || en7;
  assign en5 = !s5_valid || en6;
  assign en4 = !s4_valid || en5;
  assign en3 = !s3_valid || en4;
  assign en2 = !s2_valid || en3;
  assign en1 = !s1_valid || en2;

  assign in_stall = !en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
      s6_valid <= 1'b0;
      s7_valid <= 1'b0;
    end else begin
      if (en1) s1_valid <= in_valid;
      if (en2) s2_valid <= s1_valid;
      if (en3) s3_valid <= s2_valid;
      if (en4) s4_valid <= s3_valid;
      if (en5) s5_valid <= s4_valid;
      if (en6) s6_valid <= s5_valid;
      if (en7) s7_valid <= s6_valid;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: coordinate differences, one bit wider than the coordinates.
  // L-T, R-T and B-T feed the convexity crosses; B-R and B-L the inner angle.
  // T-R and T-L are the negatives of R-T and L-T, and their signs cancel in
  // every product that uses them, so R-T and L-T stand in for them.
  // --------------------------------------------------------------------------
  logic signed [DW-1:0] s1_ltx, s1_lty, s1_rtx, s1_rty, s1_btx, s1_bty;
  logic signed [DW-1:0] s1_brx, s1_bry, s1_blx, s1_bly;
  logic                 s1_same;

  function automatic logic signed [DW-1:0] sub_ext(
    input logic signed [COORD_BITS-1:0] a,
    input logic signed [COORD_BITS-1:0] b
  );
    sub_ext = $signed({a[COORD_BITS-1], a}) - $signed({b[COORD_BITS-1], b});
  endfunction

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_ltx  <= sub_ext(left_x, top_x);
      s1_lty  <= sub_ext(left_y, top_y);
      s1_rtx  <= sub_ext(right_x, top_x);
      s1_rty  <= sub_ext(right_y, top_y);
      s1_btx  <= sub_ext(bottom_x, top_x);
      s1_bty  <= sub_ext(bottom_y, top_y);
      s1_brx  <= sub_ext(bottom_x, right_x);
      s1_bry  <= sub_ext(bottom_y, right_y);
      s1_blx  <= sub_ext(bottom_x, left_x);
      s1_bly  <= sub_ext(bottom_y, left_y);
      s1_same <= same_vertex;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: twelve independent signed products of differences.
  // --------------------------------------------------------------------------
  logic signed [PW-1:0] s2_c1a, s2_c1b, s2_c2a, s2_c2b;
  logic signed [PW-1:0] s2_saa, s2_sab, s2_sba, s2_sbb;
  logic signed [PW-1:0] s2_sca, s2_scb, s2_sda, s2_sdb;
  logic                 s2_same;

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_c1a  <= PW'(s1_ltx * s1_bty);
      s2_c1b  <= PW'(s1_lty * s1_btx);
      s2_c2a  <= PW'(s1_rtx * s1_bty);
      s2_c2b  <= PW'(s1_rty * s1_btx);
      s2_saa  <= PW'(s1_rtx * s1_ltx);
      s2_sab  <= PW'(s1_rty * s1_lty);
      s2_sba  <= PW'(s1_brx * s1_blx);
      s2_sbb  <= PW'(s1_bry * s1_bly);
      s2_sca  <= PW'(s1_rtx * s1_lty);
      s2_scb  <= PW'(s1_rty * s1_ltx);
      s2_sda  <= PW'(s1_brx * s1_bly);
      s2_sdb  <= PW'(s1_bry * s1_blx);
      s2_same <= s1_same;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: crosses and dots as sums of two products.
  // --------------------------------------------------------------------------
  logic signed [SW-1:0] s3_c1, s3_c2, s3_sa, s3_sb, s3_sc, s3_sd;
  logic                 s3_same;

  function automatic logic signed [SW-1:0] ext_p(input logic signed [PW-1:0] p);
    ext_p = $signed({p[PW-1], p});
  endfunction

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_c1   <= ext_p(s2_c1a) - ext_p(s2_c1b);
      s3_c2   <= ext_p(s2_c2a) - ext_p(s2_c2b);
      s3_sa   <= ext_p(s2_saa) + ext_p(s2_sab);
      s3_sb   <= ext_p(s2_sba) + ext_p(s2_sbb);
      s3_sc   <= ext_p(s2_sca) - ext_p(s2_scb);
      s3_sd   <= ext_p(s2_sda) - ext_p(s2_sdb);
      s3_same <= s2_same;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: early verdicts, magnitudes and signs for the mixed sum.
  // --------------------------------------------------------------------------
  logic          s3_not_convex, s3_sa_ok, s3_sb_ok;
  logic signed [SW:0] s3_sa_tol, s3_sb_tol;
  verdict_t      s3_pre;
  logic          s3_need_sum;

  assign s3_not_convex = s3_c1[SW-1] || (!s3_c2[SW-1] && (s3_c2 != '0));
  assign s3_sa_tol     = $signed({s3_sa[SW-1], s3_sa}) + TOL_S;
  assign s3_sb_tol     = $signed({s3_sb[SW-1], s3_sb}) + TOL_S;
  assign s3_sa_ok      = !s3_sa_tol[SW];
  assign s3_sb_ok      = !s3_sb_tol[SW];

  always_comb begin
    s3_need_sum = 1'b0;
    if (s3_same) begin
      s3_pre = VERDICT_SAME;
    end else if (s3_not_convex) begin
      s3_pre = VERDICT_NOT_CONVEX;
    end else if (s3_sa_ok && s3_sb_ok) begin
      s3_pre = VERDICT_ACUTE;
    end else if (s3_sa[SW-1] && s3_sb[SW-1]) begin
      s3_pre = VERDICT_FLIP;
    end else begin
      s3_pre      = VERDICT_SUM_PASS;
      s3_need_sum = 1'b1;
    end
  end

  function automatic logic [MW-1:0] mag_of(input logic signed [SW-1:0] v);
    mag_of = v[SW-1] ? MW'(-v) : MW'(v);
  endfunction

  logic [MW-1:0] s4_msc, s4_msd, s4_msa, s4_msb;
  logic          s4_nsa, s4_nsb, s4_need_sum;
  verdict_t      s4_pre;

  always_ff @(posedge clk) begin
    if (en4) begin
      s4_msc      <= mag_of(s3_sc);
      s4_msd      <= mag_of(s3_sd);
      s4_msa      <= mag_of(s3_sa);
      s4_msb      <= mag_of(s3_sb);
      s4_nsa      <= s3_sa[SW-1];
      s4_nsb      <= s3_sb[SW-1];
      s4_need_sum <= s3_need_sum;
      s4_pre      <= s3_pre;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: partial products of |Sc|*|Sb| and |Sd|*|Sa|, halves split at LO.
  // --------------------------------------------------------------------------
  logic [2*LO-1:0]  s5_p1ll, s5_p2ll;
  logic [LO+HI-1:0] s5_p1lh, s5_p1hl, s5_p2lh, s5_p2hl;
  logic [2*HI-1:0]  s5_p1hh, s5_p2hh;
  logic             s5_nsa, s5_nsb, s5_need_sum;
  verdict_t         s5_pre;

  always_ff @(posedge clk) begin
    if (en5) begin
      s5_p1ll     <= s4_msc[LO-1:0] * s4_msb[LO-1:0];
      s5_p1lh     <= (LO + HI)'(s4_msc[LO-1:0] * s4_msb[MW-1:LO]);
      s5_p1hl     <= (LO + HI)'(s4_msc[MW-1:LO] * s4_msb[LO-1:0]);
      s5_p1hh     <= s4_msc[MW-1:LO] * s4_msb[MW-1:LO];
      s5_p2ll     <= s4_msd[LO-1:0] * s4_msa[LO-1:0];
      s5_p2lh     <= (LO + HI)'(s4_msd[LO-1:0] * s4_msa[MW-1:LO]);
      s5_p2hl     <= (LO + HI)'(s4_msd[MW-1:LO] * s4_msa[LO-1:0]);
      s5_p2hh     <= s4_msd[MW-1:LO] * s4_msa[MW-1:LO];
      s5_nsa      <= s4_nsa;
      s5_nsb      <= s4_nsb;
      s5_need_sum <= s4_need_sum;
      s5_pre      <= s4_pre;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 6: recombine the partials into the two unsigned magnitudes.
  // --------------------------------------------------------------------------
  logic [FW-1:0] s6_p1, s6_p2;
  logic          s6_nsa, s6_nsb, s6_need_sum;
  verdict_t      s6_pre;

  always_ff @(posedge clk) begin
    if (en6) begin
      s6_p1 <= (FW'(s5_p1hh) << (2 * LO)) + (FW'(s5_p1lh) << LO)
             + (FW'(s5_p1hl) << LO) + FW'(s5_p1ll);
      s6_p2 <= (FW'(s5_p2hh) << (2 * LO)) + (FW'(s5_p2lh) << LO)
             + (FW'(s5_p2hl) << LO) + FW'(s5_p2ll);
      s6_nsa      <= s5_nsa;
      s6_nsb      <= s5_nsb;
      s6_need_sum <= s5_need_sum;
      s6_pre      <= s5_pre;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 7: signed mixed sum Sc*Sb + Sa*Sd + tolerance, final verdict.
  // The sign of each product follows the dot term, the cross is a magnitude.
  // --------------------------------------------------------------------------
  logic signed [SUMW-1:0] s6_t1, s6_t2, s6_sum;
  verdict_t               s6_final;

  assign s6_t1  = s6_nsb ? -$signed({2'b00, s6_p1}) : $signed({2'b00, s6_p1});
  assign s6_t2  = s6_nsa ? -$signed({2'b00, s6_p2}) : $signed({2'b00, s6_p2});
  assign s6_sum = s6_t1 + s6_t2 + TOL_SUM;

  always_comb begin
    s6_final = s6_pre;
    if (s6_need_sum) begin
      s6_final = s6_sum[SUMW-1] ? VERDICT_FLIP : VERDICT_SUM_PASS;
    end
  end

  verdict_t s7_verdict;

  always_ff @(posedge clk) begin
    if (en7) begin
      s7_verdict <= s6_final;
    end
  end

  // Output beat straight from the last stage register.
  assign out_valid = s7_valid;
  assign verdict   = s7_verdict;
  assign keep_edge = (s7_verdict != VERDICT_FLIP);

endmodule

// ===== dv/tb_delaunay_edge_legality_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_delaunay_edge_legality_test: self-checking bench for the edge legality test
// Drives quadrilaterals through the valid/stall input channel. A scoreboard
// predicts each verdict with exact wide arithmetic and matches it in order
// against the result beats. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_delaunay_edge_legality_test
  import deltest_pkg::*;
();

  localparam int COORD_BITS = 16;
  localparam int TOLERANCE  = 0;
  localparam int DRAIN_CYCLES = 20;        // well past the seven-stage latency
  localparam int RANDOM_QUADS = 500;
  localparam int SEGMENT_LEN  = 40;        // random quads per idling regime
  localparam int EXTREMES[7] = '{-32768, -32767, -1, 0, 1, 32766, 32767};

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct {
    coord_t left_x, left_y;
    coord_t right_x, right_y;
    coord_t top_x, top_y;
    coord_t bottom_x, bottom_y;
    logic   same_vertex;
  } quad_t;

  // --------------------------------------------------------------------------
  // Scoreboard: predict the verdict of each accepted quad and match the
  // result beats against those predictions, oldest first.
  // --------------------------------------------------------------------------
  class edge_scoreboard;
    verdict_t pending_verdicts[$];
    int       errors = 0;

    // Exact swap test; every product fits a longint, the mixed sum needs 128 bits.
    function verdict_t judge_edge(quad_t q);
      longint lx, ly, rx, ry, tx, ty, bx, by;
      longint cross_l, cross_r, sa, sb, sc, sd;
      logic signed [127:0] mag_sc, mag_sd, wide_sa, wide_sb, mix;
      lx = q.left_x;   ly = q.left_y;
      rx = q.right_x;  ry = q.right_y;
      tx = q.top_x;    ty = q.top_y;
      bx = q.bottom_x; by = q.bottom_y;
      if (q.same_vertex)
        return VERDICT_SAME;
      cross_l = (lx - tx) * (by - ty) - (ly - ty) * (bx - tx);
      cross_r = (rx - tx) * (by - ty) - (ry - ty) * (bx - tx);
      if (cross_l < 0 || cross_r > 0)
        return VERDICT_NOT_CONVEX;
      sa = (tx - rx) * (tx - lx) + (ty - ry) * (ty - ly);
      sb = (bx - rx) * (bx - lx) + (by - ry) * (by - ly);
      if (sa >= -TOLERANCE && sb >= -TOLERANCE)
        return VERDICT_ACUTE;
      if (sa < 0 && sb < 0)
        return VERDICT_FLIP;
      sc = (tx - rx) * (ty - ly) - (ty - ry) * (tx - lx);
      sd = (bx - rx) * (by - ly) - (by - ry) * (bx - lx);
      mag_sc  = (sc < 0) ? -sc : sc;
      mag_sd  = (sd < 0) ? -sd : sd;
      wide_sa = sa;
      wide_sb = sb;
      mix = mag_sc * wide_sb + wide_sa * mag_sd + TOLERANCE;
      return (mix < 0) ? VERDICT_FLIP : VERDICT_SUM_PASS;
    endfunction

    function void note_quad(quad_t q);
      pending_verdicts.push_back(judge_edge(q));
    endfunction

    function void check_verdict(logic keep, logic [2:0] verdict);
      verdict_t want;
      logic     want_keep;
      if (pending_verdicts.size() == 0) begin
        $error("result beat with no quad outstanding: keep_edge=%0b verdict=%0d",
               keep, verdict);
        errors++;
        return;
      end
      want      = pending_verdicts.pop_front();
      want_keep = (want != VERDICT_FLIP);
      if (keep !== want_keep) begin
        $error("keep_edge: expected %0b, got %0b", want_keep, keep);
        errors++;
      end
      if (verdict !== want) begin
        $error("verdict: expected %0d (%s), got %0d", want, want.name(), verdict);
        errors++;
      end
    endfunction
  endclass

  // Hold every block input at a known value from time zero.
  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  coord_t     left_x = '0, left_y = '0;
  coord_t     right_x = '0, right_y = '0;
  coord_t     top_x = '0, top_y = '0;
  coord_t     bottom_x = '0, bottom_y = '0;
  logic       same_vertex = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       keep_edge;
  logic [2:0] verdict;

  edge_scoreboard board = new();

  delaunay_edge_legality_test #(
    .COORD_BITS(COORD_BITS),
    .TOLERANCE (TOLERANCE)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .left_x     (left_x),
    .left_y     (left_y),
    .right_x    (right_x),
    .right_y    (right_y),
    .top_x      (top_x),
    .top_y      (top_y),
    .bottom_x   (bottom_x),
    .bottom_y   (bottom_y),
    .same_vertex(same_vertex),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .keep_edge  (keep_edge),
    .verdict    (verdict)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(11, 30);
  endfunction

  function automatic quad_t make_quad(int lx, int ly, int rx, int ry,
                                      int tx, int ty, int bx, int by, bit same);
    quad_t q;
    q.left_x   = coord_t'(lx); q.left_y   = coord_t'(ly);
    q.right_x  = coord_t'(rx); q.right_y  = coord_t'(ry);
    q.top_x    = coord_t'(tx); q.top_y    = coord_t'(ty);
    q.bottom_x = coord_t'(bx); q.bottom_y = coord_t'(by);
    q.same_vertex = same;
    return q;
  endfunction

  // Random quads, weighted toward well-formed convex shapes so the angle
  // tests are reached; the rest is full-range noise, tiny grids full of
  // ties, and the corners of the coordinate range.
  function automatic quad_t random_quad();
    int px[4], py[4];
    int mode, cx, cy, a, span, tmp;
    bit same;
    mode = $urandom_range(0, 99);
    same = ($urandom_range(0, 19) == 0);
    if (mode < 20) begin
      // full-range noise: every bit of every field toggles here
      for (int i = 0; i < 4; i++) begin
        px[i] = int'(coord_t'($urandom));
        py[i] = int'(coord_t'($urandom));
      end
      same = 1'($urandom_range(0, 1));
    end else if (mode < 40) begin
      // tiny grid: coincident, collinear and cocircular points abound
      for (int i = 0; i < 4; i++) begin
        px[i] = int'($urandom_range(0, 12)) - 6;
        py[i] = int'($urandom_range(0, 12)) - 6;
      end
    end else if (mode < 50) begin
      for (int i = 0; i < 4; i++) begin
        px[i] = EXTREMES[$urandom_range(0, 6)];
        py[i] = EXTREMES[$urandom_range(0, 6)];
      end
    end else begin
      // edge along x, top above it, bottom below it, then rotate by 90s
      span = ($urandom_range(0, 3) == 0) ? 8000 : 64;
      cx = int'($urandom_range(0, 32000)) - 16000;
      cy = int'($urandom_range(0, 32000)) - 16000;
      a  = $urandom_range(1, span);
      px[0] = cx - a; py[0] = cy;
      px[1] = cx + a; py[1] = cy;
      px[2] = cx + int'($urandom_range(0, 2 * a)) - a;
      py[2] = cy + int'($urandom_range(0, span));
      px[3] = cx + int'($urandom_range(0, 2 * a)) - a;
      py[3] = cy - int'($urandom_range(0, span));
      repeat ($urandom_range(0, 3)) begin
        for (int i = 0; i < 4; i++) begin
          tmp   = px[i];
          px[i] = -py[i];
          py[i] = tmp;
        end
      end
    end
    return make_quad(px[0], py[0], px[1], py[1], px[2], py[2], px[3], py[3], same);
  endfunction

  // Present one quad after an optional idle gap and hold it until accepted.
  // Drop valid only when a gap follows, so valid never toggles within a step.
  task automatic send_quad(quad_t q, int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    left_x      <= q.left_x;   left_y   <= q.left_y;
    right_x     <= q.right_x;  right_y  <= q.right_y;
    top_x       <= q.top_x;    top_y    <= q.top_y;
    bottom_x    <= q.bottom_x; bottom_y <= q.bottom_y;
    same_vertex <= q.same_vertex;
    in_valid    <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Watch both channels at each edge; values read here are the ones the
  // block saw at that edge, since every driver updates through NBAs.
  always @(posedge clk) begin : beat_monitor
    quad_t seen;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        seen.left_x   = left_x;   seen.left_y   = left_y;
        seen.right_x  = right_x;  seen.right_y  = right_y;
        seen.top_x    = top_x;    seen.top_y    = top_y;
        seen.bottom_x = bottom_x; seen.bottom_y = bottom_y;
        seen.same_vertex = same_vertex;
        board.note_quad(seen);
      end
      if (out_valid && !out_stall)
        board.check_verdict(keep_edge, verdict);
    end
  end

  // Back-pressure on the result side: runs of free flow, mostly short stalls,
  // and now and then a long free run so the pipe streams at full rate.
  initial begin : result_backpressure
    int run;
    @(negedge rst);
    @(posedge clk);
    forever begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                        : $urandom_range(1, 40);
      out_stall <= 1'b0;
      repeat (run) @(posedge clk);
      out_stall <= 1'b1;
      repeat (($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
                                          : $urandom_range(1, 3)) @(posedge clk);
    end
  end

  // Stimulus: directed corner cases, then random quads in segments that
  // are each, at random, either gapped or back-to-back input.
  initial begin : stimulus
    quad_t directed[$];
    bit    no_gaps;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // same vertex, with ordinary and extreme points
    directed.push_back(make_quad(0, 0, 10, 0, 5, 5, 5, -5, 1));
    directed.push_back(make_quad(-32768, -32768, -32768, -32768,
                                 -32768, -32768, -32768, -32768, 1));
    // all points coincident at either end of the range
    directed.push_back(make_quad(32767, 32767, 32767, 32767,
                                 32767, 32767, 32767, 32767, 0));
    directed.push_back(make_quad(-32768, -32768, -32768, -32768,
                                 -32768, -32768, -32768, -32768, 0));
    // unit square: both angles exactly right
    directed.push_back(make_quad(-1, 0, 1, 0, 0, 1, 0, -1, 0));
    // both angles acute, both obtuse
    directed.push_back(make_quad(-10, 0, 10, 0, 0, 20, 0, -20, 0));
    directed.push_back(make_quad(-10, 0, 10, 0, 0, 2, 0, -2, 0));
    // mixed: sum passes, sum fails
    directed.push_back(make_quad(-10, 0, 10, 0, 0, 20, 0, -9, 0));
    directed.push_back(make_quad(-10, 0, 10, 0, 0, 20, 0, -2, 0));
    // not convex on the left side, then on the right side
    directed.push_back(make_quad(-10, 0, 10, 0, 0, 1, -30, -1, 0));
    directed.push_back(make_quad(-10, 0, 10, 0, 0, 1, 30, -1, 0));
    // collinear points and a top point coincident with the left point
    directed.push_back(make_quad(0, 0, 4, 0, 1, 0, 3, 0, 0));
    directed.push_back(make_quad(5, 5, 9, 1, 5, 5, 7, 0, 0));
    // bottom point on the edge: top angle exactly right, bottom straight
    directed.push_back(make_quad(-1, 0, 1, 0, 0, 1, 0, 0, 0));
    // cocircular: the mixed sum is exactly zero, either side obtuse; then bottom moved out and in
    directed.push_back(make_quad(-4, -3, 4, -3, 0, 5, 0, -5, 0));
    directed.push_back(make_quad(-4, 3, 4, 3, 0, 5, 0, -5, 0));
    directed.push_back(make_quad(-4, -3, 4, -3, 0, 5, 0, -6, 0));
    directed.push_back(make_quad(-4, -3, 4, -3, 0, 5, 0, -4, 0));
    // the same circle scaled up, to load the widest products
    directed.push_back(make_quad(-16384, -12288, 16384, -12288, 0, 20480, 0, -20480, 0));
    directed.push_back(make_quad(-16384, -12288, 16384, -12288, 0, 20480, 0, -20481, 0));
    directed.push_back(make_quad(-16384, -12288, 16384, -12288, 0, 20480, 0, -20479, 0));
    // corners of the coordinate range
    directed.push_back(make_quad(-32768, -32768, 32767, 32767, -32768, 32767,
                                 32767, -32768, 0));
    directed.push_back(make_quad(-32768, 0, 32767, 0, 0, 32767, 0, -32768, 0));
    directed.push_back(make_quad(32767, -32768, -32768, 32767, 32767, 32767,
                                 -32768, -32768, 0));

    foreach (directed[i])
      send_quad(directed[i], pick_gap());

    no_gaps = 1'b0;
    for (int n = 0; n < RANDOM_QUADS; n++) begin
      if (n % SEGMENT_LEN == 0)
        no_gaps = ($urandom_range(0, 3) == 0);
      send_quad(random_quad(), no_gaps ? 0 : pick_gap());
    end
    in_valid <= 1'b0;

    // Drain: wait for every prediction to be matched, then idle a while so
    // any stray result beat still shows up.
    while (board.pending_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  // Generous cap on the run, far beyond the slowest legal completion.
  initial begin : watchdog
    #400000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
